// ----- rtl/bmcf_pkg.sv -----
// bmcf_pkg: shared types, constants and arc helpers of the budgeted min cost flow unit
// no dependencies
package bmcf_pkg;

  localparam int CAP_W    = 20;
  localparam int PAID_W   = 10;
  localparam int FLOWW_W  = CAP_W + PAID_W;
  localparam int RES_W    = 31;
  localparam int TOTAL_W  = 26;
  localparam int DIST_W   = 8;
  localparam int HOPS_W   = 8;
  localparam int BUDGET_W = 10;
  localparam int NC_W     = 7;
  localparam int CFG_W    = 10;
  localparam int CFGI_W   = 1;

  localparam logic [RES_W-1:0]   UNLIMITED = RES_W'(32'h4000_0000);
  localparam logic [TOTAL_W-1:0] FLOW_MAX  = {TOTAL_W{1'b1}};

  localparam logic [CFGI_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFGI_W-1:0] CFG_BUDGET     = 1'b1;

  typedef enum logic [1:0] {
    KIND_FREE_FWD = 2'd0,
    KIND_PAID_FWD = 2'd1,
    KIND_FREE_BWD = 2'd2,
    KIND_PAID_BWD = 2'd3
  } kind_t;

  typedef struct packed {
    logic                    start;
    logic [BUDGET_W-1:0]     dividend;
    logic [DIST_W-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [BUDGET_W-1:0]     quotient;
  } div_rsp_t;

  // residual capacity of one arc kind; flow words are {free, paid}
  function automatic logic [RES_W-1:0] residual(kind_t k, logic [CAP_W-1:0] cap,
                                                logic [FLOWW_W-1:0] fuv,
                                                logic [FLOWW_W-1:0] fvu);
    logic [RES_W-1:0] r;
    r = '0;
    case (k)
      KIND_FREE_FWD: r = (cap != '0) ? RES_W'(cap - fuv[FLOWW_W-1:PAID_W]) : '0;
      KIND_PAID_FWD: r = (cap != '0) ? (UNLIMITED - RES_W'(fuv[PAID_W-1:0])) : '0;
      KIND_FREE_BWD: r = RES_W'(fvu[FLOWW_W-1:PAID_W]);
      default:       r = RES_W'(fvu[PAID_W-1:0]);
    endcase
    return r;
  endfunction

  function automatic logic signed [DIST_W-1:0] kind_cost(kind_t k);
    logic signed [DIST_W-1:0] c;
    c = '0;
    case (k)
      KIND_PAID_FWD: c = DIST_W'(1);
      KIND_PAID_BWD: c = -DIST_W'(1);
      default:       c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/bmcf_ram.sv -----
// bmcf_ram: generic single write port, single read port ram with registered read
// no dependencies
module bmcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/bmcf_div.sv -----
// bmcf_div: restoring divider, one quotient bit per cycle
// depends on bmcf_pkg
module bmcf_div
  import bmcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(BUDGET_W + 1);

  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [BUDGET_W-1:0] quo_r;
  logic [DIST_W:0]     rem_r;
  logic [DIST_W-1:0]   dvs_r;
  logic [DIST_W:0]     trial;

  assign trial = {rem_r[DIST_W-1:0], quo_r[BUDGET_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(BUDGET_W);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_r <= trial - {1'b0, dvs_r};
          quo_r <= {quo_r[BUDGET_W-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[BUDGET_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/budgeted_min_cost_flow_unit.sv -----
// budgeted_min_cost_flow_unit: top level, capacity load, path search sequencer and augmentation
// depends on bmcf_pkg, bmcf_ram and bmcf_div
// Matrix entries are taken one per cycle while idle and stored in a capacity ram. The entry marked
// last starts the flow computation, during which in_ready is low: the flow ram is first cleared,
// one word a cycle, over all (2^ceil(log2 MAX_NODES))^2 words (4096 at 64 nodes). Then each
// shortest path search is a queue-free Bellman-Ford sweep that visits every ordered vertex pair
// of a reached vertex, reading the capacity and both flow words and trying the four arc kinds in
// turn, for up to node_count rounds, capped at MAX_NODES. Each path is then traced hop by hop for
// its bottleneck residual, capped by a divider run for a costed path, and augmented hop by hop. The
// total flow is presented on out_max_flow and the block takes new items once it has been accepted.
module budgeted_min_cost_flow_unit
  import bmcf_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [5:0]          in_row,
  input  logic [5:0]          in_col,
  input  logic [CAP_W-1:0]    in_capacity,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  out_max_flow,
  input  logic                cfg_we,
  input  logic [CFGI_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * IDX_W;
  localparam int REC_W = DIST_W + HOPS_W + IDX_W + 2;

  typedef enum logic [24:0] {
    S_IDLE   = 25'd1 << 0,
    S_CLEAR  = 25'd1 << 1,
    S_SINIT  = 25'd1 << 2,
    S_USTART = 25'd1 << 3,
    S_UWAIT  = 25'd1 << 4,
    S_VSTART = 25'd1 << 5,
    S_VRD2   = 25'd1 << 6,
    S_VRD3   = 25'd1 << 7,
    S_VKIND  = 25'd1 << 8,
    S_VWB    = 25'd1 << 9,
    S_PCHK   = 25'd1 << 10,
    S_PCHK2  = 25'd1 << 11,
    S_TSTART = 25'd1 << 12,
    S_TNODE  = 25'd1 << 13,
    S_TRD2   = 25'd1 << 14,
    S_TRD3   = 25'd1 << 15,
    S_TMIN   = 25'd1 << 16,
    S_TDONE  = 25'd1 << 17,
    S_DIV    = 25'd1 << 18,
    S_CHARGE = 25'd1 << 19,
    S_CCHK   = 25'd1 << 20,
    S_ASTART = 25'd1 << 21,
    S_ANODE  = 25'd1 << 22,
    S_ARD    = 25'd1 << 23,
    S_OUT    = 25'd1 << 24
  } state_t;

  state_t                   state_r;
  logic [NC_W-1:0]          nc_r;
  logic [BUDGET_W-1:0]      budget_r;
  logic [BUDGET_W-1:0]      rb_r;
  logic [TOTAL_W-1:0]       total_r;
  logic [NW-1:0]            n_r;
  logic [AW-1:0]            clr_r;
  logic [NW-1:0]            u_r;
  logic [NW-1:0]            v_r;
  logic [NW-1:0]            round_r;
  logic [NW-1:0]            steps_r;
  logic                     changed_r;
  kind_t                    k_r;
  logic signed [DIST_W-1:0] du_r;
  logic [HOPS_W-1:0]        hu_r;
  logic [MAX_NODES-1:0]     reached_r;
  logic                     rv_r;
  logic signed [DIST_W-1:0] dv_r;
  logic [HOPS_W-1:0]        hv_r;
  logic [IDX_W-1:0]         pv_r;
  kind_t                    kv_r;
  logic                     upd_r;
  logic [CAP_W-1:0]         cap_r;
  logic [FLOWW_W-1:0]       fuv_r;
  logic [FLOWW_W-1:0]       fvu_r;
  logic signed [DIST_W-1:0] d_r;
  logic [RES_W-1:0]         b_r;
  logic [RES_W-1:0]         cnt_r;
  logic [IDX_W-1:0]         p_r;
  kind_t                    tk_r;
  logic [AW-1:0]            aaddr_r;

  logic                     cap_we;
  logic [AW-1:0]            cap_waddr;
  logic [CAP_W-1:0]         cap_rdata;
  logic [AW-1:0]            mem_raddr;
  logic                     flow_we;
  logic [AW-1:0]            flow_waddr;
  logic [FLOWW_W-1:0]       flow_wdata;
  logic [FLOWW_W-1:0]       flow_rdata;
  logic                     node_we;
  logic [IDX_W-1:0]         node_waddr;
  logic [REC_W-1:0]         node_wdata;
  logic [IDX_W-1:0]         node_raddr;
  logic [REC_W-1:0]         node_rdata;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic signed [DIST_W-1:0] nr_dist;
  logic [HOPS_W-1:0]        nr_hops;
  logic [IDX_W-1:0]         nr_pred;
  kind_t                    nr_kind;
  logic [IDX_W-1:0]         ui;
  logic [IDX_W-1:0]         vi;
  logic [NW-1:0]            last_v;
  logic [RES_W-1:0]         vres;
  logic signed [DIST_W-1:0] nd;
  logic [HOPS_W-1:0]        nh;
  logic                     better;
  logic [RES_W-1:0]         tres;
  logic [RES_W-1:0]         quo_ext;
  logic [BUDGET_W+DIST_W-1:0] charge;
  logic [31:0]              sum;
  logic                     in_fire;
  logic                     in_range;
  logic [AW-1:0]            anode_addr;

  function automatic logic signed [DIST_W-1:0] nr_rec_dist(logic [REC_W-1:0] rec);
    return rec[REC_W-1 -: DIST_W];
  endfunction

  assign nr_dist = nr_rec_dist(node_rdata);
  assign nr_hops = node_rdata[HOPS_W+IDX_W+1 -: HOPS_W];
  assign nr_pred = node_rdata[IDX_W+1 -: IDX_W];
  assign nr_kind = kind_t'(node_rdata[1:0]);

  assign ui      = u_r[IDX_W-1:0];
  assign vi      = v_r[IDX_W-1:0];
  assign last_v  = n_r - NW'(1);
  assign in_fire = in_valid && in_ready;
  assign in_range = ({1'b0, in_row} < 7'(MAX_NODES)) && ({1'b0, in_col} < 7'(MAX_NODES));

  assign vres   = residual(k_r, cap_r, fuv_r, fvu_r);
  assign nd     = du_r + kind_cost(k_r);
  assign nh     = hu_r + HOPS_W'(1);
  assign better = (vres != '0) && (!rv_r || (nd < dv_r) || ((nd == dv_r) && (nh < hv_r)));
  assign tres   = residual(tk_r, cap_r, fuv_r, fvu_r);
  assign quo_ext = RES_W'(div_rsp.quotient);
  assign charge = BUDGET_W'(cnt_r) * DIST_W'(d_r);
  assign sum    = 32'(total_r) + 32'(cnt_r);
  assign anode_addr = ((nr_kind == KIND_FREE_FWD) || (nr_kind == KIND_PAID_FWD)) ?
                      {nr_pred, vi} : {vi, nr_pred};

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_max_flow = total_r;

  assign cap_we    = in_fire && in_range;
  assign cap_waddr = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};

  always_comb begin
    mem_raddr = {ui, vi};
    case (state_r)
      S_VRD2:  mem_raddr = {vi, ui};
      S_TNODE: mem_raddr = {nr_pred, vi};
      S_TRD2:  mem_raddr = {vi, p_r};
      default: mem_raddr = {ui, vi};
    endcase
  end

  always_comb begin
    node_raddr = vi;
    case (state_r)
      S_USTART: node_raddr = ui;
      S_PCHK:   node_raddr = last_v[IDX_W-1:0];
      default:  node_raddr = vi;
    endcase
  end

  always_comb begin
    node_we    = 1'b0;
    node_waddr = vi;
    node_wdata = {dv_r, hv_r, pv_r, kv_r};
    if (state_r == S_SINIT) begin
      node_we    = 1'b1;
      node_waddr = '0;
      node_wdata = '0;
    end else if (state_r == S_VWB) begin
      node_we = upd_r;
    end
  end

  always_comb begin
    flow_we    = 1'b0;
    flow_waddr = aaddr_r;
    flow_wdata = flow_rdata;
    if (state_r == S_CLEAR) begin
      flow_we    = 1'b1;
      flow_waddr = clr_r;
      flow_wdata = '0;
    end else if (state_r == S_ARD) begin
      flow_we = 1'b1;
      case (tk_r)
        KIND_FREE_FWD: flow_wdata[FLOWW_W-1:PAID_W] = flow_rdata[FLOWW_W-1:PAID_W] + CAP_W'(cnt_r);
        KIND_PAID_FWD: flow_wdata[PAID_W-1:0] = flow_rdata[PAID_W-1:0] + PAID_W'(cnt_r);
        KIND_FREE_BWD: flow_wdata[FLOWW_W-1:PAID_W] = flow_rdata[FLOWW_W-1:PAID_W] - CAP_W'(cnt_r);
        default:       flow_wdata[PAID_W-1:0] = flow_rdata[PAID_W-1:0] - PAID_W'(cnt_r);
      endcase
    end
  end

  assign div_req.start    = (state_r == S_TDONE) && (d_r > 0);
  assign div_req.dividend = rb_r;
  assign div_req.divisor  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      nc_r      <= NC_W'(2);
      budget_r  <= '0;
      rb_r      <= '0;
      total_r   <= '0;
      reached_r <= '0;
      changed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: nc_r <= cfg_data[NC_W-1:0];
          CFG_BUDGET:     budget_r <= cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_last) begin
            n_r     <= (nc_r > NC_W'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(nc_r);
            rb_r    <= budget_r;
            total_r <= '0;
            clr_r   <= '0;
            state_r <= ((nc_r < NC_W'(2))) ? S_OUT : S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == {AW{1'b1}}) begin
            state_r <= S_SINIT;
          end
        end
        S_SINIT: begin
          reached_r    <= MAX_NODES'(1);
          round_r      <= '0;
          changed_r    <= 1'b0;
          u_r          <= '0;
          state_r      <= S_USTART;
        end
        S_USTART: begin
          if (u_r == n_r) begin
            if (!changed_r || (round_r == last_v)) begin
              state_r <= S_PCHK;
            end else begin
              round_r   <= round_r + NW'(1);
              changed_r <= 1'b0;
              u_r       <= '0;
            end
          end else if (!reached_r[ui]) begin
            u_r <= u_r + NW'(1);
          end else begin
            state_r <= S_UWAIT;
          end
        end
        S_UWAIT: begin
          du_r    <= nr_dist;
          hu_r    <= nr_hops;
          v_r     <= NW'(1);
          state_r <= S_VSTART;
        end
        S_VSTART: begin
          if (v_r == n_r) begin
            u_r     <= u_r + NW'(1);
            state_r <= S_USTART;
          end else if (v_r == u_r) begin
            v_r <= v_r + NW'(1);
          end else begin
            state_r <= S_VRD2;
          end
        end
        S_VRD2: begin
          cap_r   <= cap_rdata;
          fuv_r   <= flow_rdata;
          rv_r    <= reached_r[vi];
          dv_r    <= nr_dist;
          hv_r    <= nr_hops;
          pv_r    <= nr_pred;
          kv_r    <= nr_kind;
          upd_r   <= 1'b0;
          state_r <= S_VRD3;
        end
        S_VRD3: begin
          fvu_r   <= flow_rdata;
          k_r     <= KIND_FREE_FWD;
          state_r <= S_VKIND;
        end
        S_VKIND: begin
          if (better) begin
            rv_r      <= 1'b1;
            dv_r      <= nd;
            hv_r      <= nh;
            pv_r      <= ui;
            kv_r      <= k_r;
            upd_r     <= 1'b1;
            changed_r <= 1'b1;
          end
          if (k_r == KIND_PAID_BWD) begin
            state_r <= S_VWB;
          end else begin
            k_r <= kind_t'(k_r + 2'd1);
          end
        end
        S_VWB: begin
          if (upd_r) begin
            reached_r[vi] <= 1'b1;
          end
          v_r     <= v_r + NW'(1);
          state_r <= S_VSTART;
        end
        S_PCHK: begin
          state_r <= S_PCHK2;
        end
        S_PCHK2: begin
          d_r     <= nr_dist;
          b_r     <= UNLIMITED;
          v_r     <= last_v;
          steps_r <= '0;
          if (!reached_r[last_v[IDX_W-1:0]]) begin
            state_r <= S_OUT;
          end else if ((nr_dist > 0) && (BUDGET_W'(nr_dist) > rb_r)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_TSTART;
          end
        end
        S_TSTART: begin
          if (v_r == '0) begin
            state_r <= S_TDONE;
          end else if (steps_r == n_r) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_TNODE;
          end
        end
        S_TNODE: begin
          p_r     <= nr_pred;
          tk_r    <= nr_kind;
          state_r <= S_TRD2;
        end
        S_TRD2: begin
          cap_r   <= cap_rdata;
          fuv_r   <= flow_rdata;
          state_r <= S_TRD3;
        end
        S_TRD3: begin
          fvu_r   <= flow_rdata;
          state_r <= S_TMIN;
        end
        S_TMIN: begin
          if (tres < b_r) begin
            b_r <= tres;
          end
          v_r     <= NW'(p_r);
          steps_r <= steps_r + NW'(1);
          state_r <= S_TSTART;
        end
        S_TDONE: begin
          cnt_r   <= b_r;
          state_r <= (d_r > 0) ? S_DIV : S_CCHK;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (quo_ext < cnt_r) begin
              cnt_r <= quo_ext;
            end
            state_r <= S_CHARGE;
          end
        end
        S_CHARGE: begin
          rb_r    <= rb_r - charge[BUDGET_W-1:0];
          state_r <= S_CCHK;
        end
        S_CCHK: begin
          v_r     <= last_v;
          state_r <= (cnt_r == '0) ? S_OUT : S_ASTART;
        end
        S_ASTART: begin
          if (v_r == '0) begin
            total_r <= (sum >= 32'(FLOW_MAX)) ? FLOW_MAX : sum[TOTAL_W-1:0];
            state_r <= S_SINIT;
          end else begin
            state_r <= S_ANODE;
          end
        end
        S_ANODE: begin
          p_r     <= nr_pred;
          tk_r    <= nr_kind;
          aaddr_r <= anode_addr;
          state_r <= S_ARD;
        end
        S_ARD: begin
          v_r     <= NW'(p_r);
          state_r <= S_ASTART;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  bmcf_ram #(.WIDTH(CAP_W), .DEPTH(1 << AW)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_waddr),
    .wdata (in_capacity),
    .raddr (mem_raddr),
    .rdata (cap_rdata)
  );

  bmcf_ram #(.WIDTH(FLOWW_W), .DEPTH(1 << AW)) u_flow_ram (
    .clk   (clk),
    .we    (flow_we),
    .waddr (flow_waddr),
    .wdata (flow_wdata),
    .raddr ((state_r == S_ANODE) ? anode_addr : mem_raddr),
    .rdata (flow_rdata)
  );

  bmcf_ram #(.WIDTH(REC_W), .DEPTH(1 << IDX_W)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  bmcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide step");

  a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken during computation");

  a_budget_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_IDLE) && (state_r != S_OUT)) |-> (rb_r <= budget_r))
    else $error("remaining budget above budget");

endmodule

// ----- sim/tb.sv -----
// tb: self-checking bench for budgeted_min_cost_flow_unit, loads capacity matrices and
// checks each total flow against an in-bench successive shortest path predictor
// depends on bmcf_pkg and budgeted_min_cost_flow_unit
`timescale 1ns / 1ps

module tb;
  import bmcf_pkg::*;

  localparam int NODES      = 64;
  localparam int WDOG_LIMIT = 2000000;
  localparam int unsigned UNLIM = 32'h4000_0000;
  localparam int unsigned FMAX  = 32'h03FF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [5:0]          in_row;
  logic [5:0]          in_col;
  logic [CAP_W-1:0]    in_capacity;
  logic                in_last;
  logic                out_valid;
  logic                out_ready;
  logic [TOTAL_W-1:0]  out_max_flow;
  logic                cfg_we;
  logic [CFGI_W-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  budgeted_min_cost_flow_unit #(.MAX_NODES(NODES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_row(in_row), .in_col(in_col),
    .in_capacity(in_capacity), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_max_flow(out_max_flow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  bit [CAP_W-1:0] cap_tab [NODES][NODES];
  int unsigned    free_fl [NODES][NODES];
  int unsigned    paid_fl [NODES][NODES];
  int             path_cost [NODES];
  int unsigned    hop_cnt [NODES];
  int             pred    [NODES];
  kind_t          via     [NODES];
  bit             reach   [NODES];
  bit [NC_W-1:0]     nc_shadow;
  bit [BUDGET_W-1:0] budget_shadow;

  logic [TOTAL_W-1:0] flow_expect_q [$];
  int errors;
  int items_sent;
  int flows_checked;
  int idle_pct;
  int stall_pct;
  int wdog;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned arc_residual(int u, int v, kind_t k);
    case (k)
      KIND_FREE_FWD: return (cap_tab[u][v] != 0) ? cap_tab[u][v] - free_fl[u][v] : 0;
      KIND_PAID_FWD: return (cap_tab[u][v] != 0) ? UNLIM - paid_fl[u][v] : 0;
      KIND_FREE_BWD: return free_fl[v][u];
      default:       return paid_fl[v][u];
    endcase
  endfunction

  function automatic int arc_cost(kind_t k);
    case (k)
      KIND_PAID_FWD: return 1;
      KIND_PAID_BWD: return -1;
      default:       return 0;
    endcase
  endfunction

  function automatic bit find_cheapest_route(int n);
    bit changed;
    int nd;
    int unsigned nh;
    kind_t k;
    for (int i = 0; i < NODES; i++) reach[i] = 0;
    reach[0] = 1;
    path_cost[0] = 0;
    hop_cnt[0] = 0;
    for (int r = 0; r < n; r++) begin
      changed = 0;
      for (int u = 0; u < n; u++) begin
        if (!reach[u]) continue;
        for (int v = 1; v < n; v++) begin
          if (v == u) continue;
          for (int ki = 0; ki < 4; ki++) begin
            k = kind_t'(ki);
            if (arc_residual(u, v, k) == 0) continue;
            nd = path_cost[u] + arc_cost(k);
            nh = hop_cnt[u] + 1;
            if (!reach[v] || nd < path_cost[v] || (nd == path_cost[v] && nh < hop_cnt[v])) begin
              reach[v] = 1;
              path_cost[v] = nd;
              hop_cnt[v] = nh;
              pred[v] = u;
              via[v] = k;
              changed = 1;
            end
          end
        end
      end
      if (!changed) break;
    end
    return reach[n-1];
  endfunction

  function automatic int unsigned budgeted_flow(int n);
    int unsigned rb, tot, b, cnt, q, r;
    int d, v, u, steps;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) begin
        free_fl[i][j] = 0;
        paid_fl[i][j] = 0;
      end
    rb = budget_shadow;
    tot = 0;
    if (n < 2) return 0;
    while (find_cheapest_route(n)) begin
      d = path_cost[n-1];
      b = UNLIM;
      v = n - 1;
      steps = 0;
      if (d > 0 && d > rb) break;
      while (v != 0 && steps < n) begin
        r = arc_residual(pred[v], v, via[v]);
        if (r < b) b = r;
        v = pred[v];
        steps++;
      end
      if (v != 0) break;
      cnt = b;
      if (d > 0) begin
        q = rb / d;
        if (q < cnt) cnt = q;
        rb -= d * cnt;
      end
      if (cnt == 0) break;
      v = n - 1;
      while (v != 0) begin
        u = pred[v];
        case (via[v])
          KIND_FREE_FWD: free_fl[u][v] += cnt;
          KIND_PAID_FWD: paid_fl[u][v] += cnt;
          KIND_FREE_BWD: free_fl[v][u] -= cnt;
          default:       paid_fl[v][u] -= cnt;
        endcase
        v = u;
      end
      tot = (cnt >= FMAX - tot) ? FMAX : tot + cnt;
    end
    return tot;
  endfunction

  task automatic send_entry(int row, int col, int unsigned cap, bit last);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_row = row[5:0];
    in_col = col[5:0];
    in_capacity = cap[CAP_W-1:0];
    in_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    cap_tab[row][col] = cap[CAP_W-1:0];
    free_fl[row][col] = 0;
    paid_fl[row][col] = 0;
    if (last) begin
      n = (nc_shadow > NODES) ? NODES : nc_shadow;
      flow_expect_q.push_back(TOTAL_W'(budgeted_flow(n)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFGI_W-1:0] idx, int unsigned val);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    if (idx == CFG_NODE_COUNT) nc_shadow = val[NC_W-1:0];
    else budget_shadow = val[BUDGET_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int unsigned rand_cap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 0;
    if (sel < 75) return $urandom_range(1, 20);
    if (sel < 95) return $urandom_range(1, 20'hFFFFF);
    return 20'hFFFFF;
  endfunction

  // every entry of the 5 by 5 corner is loaded before any small graph is solved
  task automatic test_fill_block();
    write_reg(CFG_NODE_COUNT, 5);
    write_reg(CFG_BUDGET, 0);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_entry(i, j, rand_cap(), (i == 4 && j == 4));
  endtask

  task automatic test_special_cases();
    write_reg(CFG_NODE_COUNT, 3);
    write_reg(CFG_BUDGET, 1023);
    send_entry(0, 1, 20'hFFFFF, 0);
    send_entry(1, 2, 20'hFFFFF, 0);
    send_entry(0, 2, 0, 1);
    // self loops
    send_entry(1, 1, 5, 0);
    send_entry(0, 0, 7, 1);
    // rewritten entry
    send_entry(0, 2, 9, 0);
    send_entry(0, 2, 4, 1);
    // entries beyond the vertex count
    send_entry(4, 2, 100, 0);
    send_entry(0, 4, 50, 1);
    write_reg(CFG_BUDGET, 0);
    send_entry(2, 1, 3, 1);
    write_reg(CFG_NODE_COUNT, 1);
    send_entry(0, 0, 3, 1);
    write_reg(CFG_NODE_COUNT, 0);
    send_entry(2, 2, 0, 1);
    write_reg(CFG_NODE_COUNT, 2);
    write_reg(CFG_BUDGET, 1023);
    send_entry(0, 1, 1, 1);
    send_entry(1, 0, 20'hFFFFF, 0);
    send_entry(0, 1, 0, 1);
  endtask

  // full width graph: only source and sink rows matter, all else unreachable
  task automatic test_wide_graph();
    int unsigned nc_vals [2] = '{64, 127};
    int unsigned bud_vals [2] = '{1023, 517};
    for (int t = 0; t < 2; t++) begin
      write_reg(CFG_NODE_COUNT, nc_vals[t]);
      write_reg(CFG_BUDGET, bud_vals[t]);
      for (int j = 0; j < NODES; j++)
        send_entry(0, j, (j == 63) ? $urandom_range(1, 20'hFFFFF) :
                         (j == 0) ? 20'hFFFFF : 0, 0);
      for (int j = 0; j < NODES; j++)
        send_entry(63, j, (j == 0 || j == 63) ? $urandom_range(1, 20'hFFFFF) : 0,
                   j == 63);
    end
  endtask

  task automatic random_config();
    int sel;
    write_reg(CFG_NODE_COUNT, $urandom_range(2, 5));
    sel = $urandom_range(9);
    write_reg(CFG_BUDGET, (sel < 2) ? 0 : (sel < 4) ? 1023 : $urandom_range(1023));
  endtask

  task automatic test_random_traffic();
    int idle_v [4] = '{0, 79, 0, 18};
    int stall_v [4] = '{0, 0, 79, 18};
    int target, k, n, sets;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_v[ph];
      stall_pct = stall_v[ph];
      target = items_sent + 210;
      sets = 0;
      random_config();
      while (items_sent < target) begin
        if (sets % 8 == 7) random_config();
        n = nc_shadow;
        k = $urandom_range(1, 12);
        if ($urandom_range(99) < 80) begin
          for (int i = 0; i < k; i++)
            send_entry($urandom_range(n - 1), $urandom_range(n - 1), rand_cap(), i == k - 1);
        end else begin
          for (int i = 0; i < k; i++)
            send_entry($urandom_range(63), $urandom_range(63), $urandom_range(20'hFFFFF),
                       i == k - 1);
        end
        sets++;
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (flow_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected max_flow expected none actual %0d", $realtime, out_max_flow);
      end else begin
        if (out_max_flow !== flow_expect_q[0]) begin
          errors++;
          $display("%0t: max_flow mismatch expected %0d actual %0d", $realtime,
                   flow_expect_q[0], out_max_flow);
        end
        void'(flow_expect_q.pop_front());
        flows_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else if (wdog >= WDOG_LIMIT) begin
      $display("%0t: timeout with no handshake", $realtime);
      $display("RESULT: ERROR");
      $finish;
    end else wdog <= wdog + 1;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    flows_checked = 0;
    idle_pct = 0;
    stall_pct = 0;
    wdog = 0;
    nc_shadow = 2;
    budget_shadow = 0;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) begin
        cap_tab[i][j] = 0;
        free_fl[i][j] = 0;
        paid_fl[i][j] = 0;
      end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_row = '0;
    in_col = '0;
    in_capacity = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_fill_block();
    test_special_cases();
    test_wide_graph();
    test_random_traffic();

    wait_idle();
    repeat (200) @(posedge clk);
    $display("matrix entries loaded: %0d, flow results checked: %0d", items_sent, flows_checked);
    $display("covered vertex counts 0 to 127, budgets 0 to 1023, sender and receiver pauses");
    if (errors == 0 && flow_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bmcf_pkg.sv
rtl/bmcf_ram.sv
rtl/bmcf_div.sv
rtl/budgeted_min_cost_flow_unit.sv
sim/tb.sv
